// ===== sv/percentile_linear_interp_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Percentile unit assertion macros
// Concurrent assertion wrappers used by the percentile interpolation modules.
// They sample on aclk and are disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef PERCENTILE_LINEAR_INTERP_UNIT_ASSERT_SVH
`define PERCENTILE_LINEAR_INTERP_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PLI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define PLI_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);
`else
`define PLI_ASSERT(label, prop, msg)
`define PLI_NEVER(label, expr, msg)
`endif
`endif

// ===== sv/pli_pkg.sv =====
// ----------------------------------------------------------------------------
// Percentile unit package
// Shared widths, constants, controller states and the command and status
// groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pli_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int PCT_W       = 17;
    localparam int FRAC_W      = 16;
    localparam int USED_W      = 9;
    localparam int M_TDATA_W   = 48;

    localparam logic [PCT_W-1:0] PCT_ONE   = 17'd65536;
    localparam logic [PCT_W-1:0] PCT_RESET = 17'd32768;

    typedef enum logic [3:0] {
        S_LOAD,
        S_SETUP,
        S_KEY,
        S_KEYW,
        S_SCAN,
        S_DRAIN,
        S_CHECK,
        S_DIFF,
        S_MUL,
        S_ADD
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic key_rd;
        logic key_cap;
        logic scan_rd;
        logic check;
        logic next_key;
        logic diff;
        logic mul;
        logic finish;
    } pli_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic found_all;
        logic out_free;
    } pli_sts_t;

endpackage

`default_nettype wire

// ===== sv/pli_ctrl.sv =====
// ----------------------------------------------------------------------------
// Percentile unit controller
// Sequences loading, the rank scan over the stored values, and the
// interpolation steps, and issues commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module pli_ctrl
    import pli_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    input  wire logic     s_tlast,
    output logic          s_tready,
    input  wire pli_sts_t sts,
    output pli_cmd_t      cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_LOAD: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid && s_tlast) begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = S_KEY;
            end
            S_KEY: begin
                cmd.key_rd = 1'b1;
                state_next = S_KEYW;
            end
            S_KEYW: begin
                cmd.key_cap = 1'b1;
                state_next  = S_SCAN;
            end
            S_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                cmd.check = 1'b1;
                if (sts.found_all) begin
                    state_next = S_DIFF;
                end else begin
                    cmd.next_key = 1'b1;
                    state_next   = S_KEY;
                end
            end
            S_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/pli_datapath.sv =====
// ----------------------------------------------------------------------------
// Percentile unit datapath
// Value store, rank counters, index computation, interpolation multiplier
// and the result register with its transfer handshake.
// ----------------------------------------------------------------------------
`default_nettype none
`include "percentile_linear_interp_unit_assert.svh"

module pli_datapath
    import pli_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire pli_cmd_t             cmd,
    output pli_sts_t                  sts,
    input  wire logic [SAMPLE_W-1:0]  s_tdata,
    input  wire logic                 cfg_valid,
    input  wire logic [PCT_W-1:0]     cfg_data,
    output logic                      cfg_ready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    logic [SAMPLE_W-1:0]        mem [CAPACITY];
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic [AW-1:0]              rd_addr;

    logic [PCT_W-1:0]           pct_reg;
    logic [CW-1:0]              count_reg;
    logic                       ovf_reg;
    logic [CW-1:0]              n_minus1;
    logic [PCT_W-1:0]           pct_sat;
    logic [PCT_W+CW-1:0]        idx_full;
    logic [CW-1:0]              lo_reg;
    logic [FRAC_W-1:0]          frac_reg;
    logic                       need_hi_reg;

    logic [CW-1:0]              i_reg;
    logic [CW-1:0]              j_reg;
    logic                       cmp_vld_reg;
    logic signed [SAMPLE_W-1:0] key_reg;
    logic [CW-1:0]              less_reg;
    logic [CW-1:0]              eq_reg;
    logic [CW-1:0]              rank_end;
    logic [CW-1:0]              hi_pos;
    logic                       lo_hit;
    logic                       hi_hit;

    logic signed [SAMPLE_W-1:0] base_reg;
    logic signed [SAMPLE_W-1:0] hi_reg;
    logic                       base_found_reg;
    logic                       hi_found_reg;
    logic signed [SAMPLE_W:0]   diff_reg;
    logic signed [FRAC_W:0]     frac_s;
    logic signed [49:0]         prod_reg;
    logic signed [49:0]         prod_shr;
    logic signed [49:0]         res_wide;
    logic [CW+USED_W-1:0]       n_ext;

    logic                       out_vld_reg;
    logic [SAMPLE_W-1:0]        out_val_reg;
    logic [USED_W-1:0]          out_used_reg;
    logic                       out_drop_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pct_reg <= PCT_RESET;
        end else if (cfg_valid) begin
            pct_reg <= cfg_data;
        end
    end

    // Value store: one write port for loading, one registered read port.
    assign rd_addr = cmd.key_rd ? i_reg[AW-1:0] : j_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load && (count_reg < CAP_COUNT)) begin
            mem[count_reg[AW-1:0]] <= s_tdata;
        end
        rd_data_reg <= $signed(mem[rd_addr]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (cmd.finish) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (cmd.load) begin
            if (count_reg < CAP_COUNT) begin
                count_reg <= count_reg + 1'b1;
            end else begin
                ovf_reg <= 1'b1;
            end
        end
    end

    assign n_minus1 = count_reg - 1'b1;
    assign pct_sat  = (pct_reg > PCT_ONE) ? PCT_ONE : pct_reg;
    assign idx_full = pct_sat * n_minus1;

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            lo_reg      <= idx_full[FRAC_W +: CW];
            frac_reg    <= idx_full[FRAC_W-1:0];
            need_hi_reg <= (idx_full[FRAC_W-1:0] != '0);
        end
    end

    // Rank scan: count stored values below and equal to the current key.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_vld_reg <= 1'b0;
        end else begin
            cmp_vld_reg <= cmd.scan_rd;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            i_reg <= '0;
        end else if (cmd.next_key) begin
            i_reg <= i_reg + 1'b1;
        end
        if (cmd.key_cap) begin
            key_reg  <= rd_data_reg;
            j_reg    <= '0;
            less_reg <= '0;
            eq_reg   <= '0;
        end else begin
            if (cmd.scan_rd) begin
                j_reg <= j_reg + 1'b1;
            end
            if (cmp_vld_reg) begin
                if (rd_data_reg < key_reg) begin
                    less_reg <= less_reg + 1'b1;
                end
                if (rd_data_reg == key_reg) begin
                    eq_reg <= eq_reg + 1'b1;
                end
            end
        end
    end

    assign rank_end = less_reg + eq_reg;
    assign hi_pos   = lo_reg + 1'b1;
    assign lo_hit   = (less_reg <= lo_reg) && (lo_reg < rank_end);
    assign hi_hit   = (less_reg <= hi_pos) && (hi_pos < rank_end);

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            base_found_reg <= 1'b0;
            hi_found_reg   <= 1'b0;
        end else if (cmd.check) begin
            if (lo_hit) begin
                base_reg       <= key_reg;
                base_found_reg <= 1'b1;
            end
            if (hi_hit) begin
                hi_reg       <= key_reg;
                hi_found_reg <= 1'b1;
            end
        end
    end

    assign sts.scan_last = (j_reg == n_minus1);
    assign sts.found_all = (base_found_reg || lo_hit) &&
                           (!need_hi_reg || hi_found_reg || hi_hit);
    assign sts.out_free  = !out_vld_reg || m_tready;

    // Interpolation: difference, product, then floor shift and add.
    assign frac_s   = $signed({1'b0, frac_reg});
    assign prod_shr = prod_reg >>> FRAC_W;
    assign res_wide = $signed({{(50-SAMPLE_W){base_reg[SAMPLE_W-1]}}, base_reg}) + prod_shr;
    assign n_ext    = {{USED_W{1'b0}}, count_reg};

    always_ff @(posedge aclk) begin
        if (cmd.diff) begin
            if (need_hi_reg) begin
                diff_reg <= $signed({hi_reg[SAMPLE_W-1], hi_reg}) -
                            $signed({base_reg[SAMPLE_W-1], base_reg});
            end else begin
                diff_reg <= '0;
            end
        end
        if (cmd.mul) begin
            prod_reg <= diff_reg * frac_s;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_val_reg  <= res_wide[SAMPLE_W-1:0];
            out_used_reg <= n_ext[USED_W-1:0];
            out_drop_reg <= ovf_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(M_TDATA_W-SAMPLE_W-USED_W-1){1'b0}},
                       out_drop_reg, out_used_reg, out_val_reg};

    `PLI_NEVER(a_count_cap, count_reg > CAP_COUNT, "Store count beyond capacity.")
    `PLI_ASSERT(a_lo_in_set, cmd.check |-> lo_reg < count_reg, "Lower index outside the set.")
    `PLI_ASSERT(a_scan_in_set, cmd.scan_rd |-> j_reg < count_reg, "Scan address outside the set.")
    `PLI_ASSERT(a_neighbors_found, cmd.diff |-> base_found_reg && (!need_hi_reg || hi_found_reg), "Interpolation started before both neighbors were found.")

endmodule

`default_nettype wire

// ===== sv/percentile_linear_interp_unit.sv =====
// ----------------------------------------------------------------------------
// Percentile linear interpolation unit
// Loads a set of signed Q16.16 values, finds the two values around the
// requested percentile by rank and interpolates linearly between them.
//
// Channel   Direction  Payload                                   Handshake
// s_        in         tdata: sample_value; tlast: last_item     tvalid/tready
// m_        out        tdata: value, items_used, dropped_flag    tvalid/tready
// cfg_      in         data: percentile_q16                      valid/ready
//
// A set of n values loads at one value per cycle. After the last value the
// rank scan reads the single read port of the value store once per value
// for each candidate key; m_tvalid rises once the interpolation is done
// and the output register is free.
// Reset is synchronous and active low; the store needs no clearing pass.
// While a result waits on m_tready the next set can load; its own
// result waits in the final step until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module percentile_linear_interp_unit
    import pli_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // [31:0] sample_value
    input  wire logic [SAMPLE_W-1:0]  s_tdata,
    input  wire logic                 s_tlast,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [31:0] percentile_value, [40:32] items_used, [41] dropped_flag
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic                 cfg_valid,
    input  wire logic [PCT_W-1:0]     cfg_data,
    output logic                      cfg_ready
);

    pli_cmd_t cmd;
    pli_sts_t sts;

    pli_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pli_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

// ===== test/tb_percentile_linear_interp_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the percentile linear interpolation unit
// Streams sets of signed Q16.16 values into the unit and predicts each
// interpolated percentile with a sort-and-interpolate model kept in the
// bench. The tests cover directed extremes, many percentile settings, a full
// store, an over-capacity set, output backpressure and random traffic.
// Results are checked field by field in arrival order.
// ----------------------------------------------------------------------------

module tb_percentile_linear_interp_unit
    import pli_pkg::*;
();

    localparam int STORE_DEPTH = 256;
    localparam int ITEM_TARGET = 1350;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic [USED_W-1:0]   used;
        logic                dropped;
    } pct_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic [SAMPLE_W-1:0]   s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [PCT_W-1:0]      cfg_data = '0;
    logic                  cfg_ready;

    // Bench copy of the unit's state.
    logic signed [SAMPLE_W-1:0] value_store [STORE_DEPTH];
    int unsigned                stored_count = 0;
    bit                         store_overflow = 1'b0;
    logic [PCT_W-1:0]           pct_setting = PCT_RESET;

    pct_result_t expected_results [$];

    bit          idling_on = 1'b1;
    int unsigned hold_cycles = 0;
    int unsigned rx_gap = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned sets_closed = 0;
    int unsigned results_checked = 0;
    int unsigned overflow_sets = 0;
    int unsigned pct_writes = 0;

    percentile_linear_interp_unit #(
        .CAPACITY(STORE_DEPTH)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_valid(cfg_valid),
        .cfg_data (cfg_data),
        .cfg_ready(cfg_ready)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic predict_transfer(input logic [SAMPLE_W-1:0] sample, input logic last);
        logic signed [SAMPLE_W-1:0] sorted_vals [STORE_DEPTH];
        logic signed [SAMPLE_W-1:0] key;
        logic [PCT_W-1:0]           pct;
        longint                     idx;
        longint                     span;
        longint                     interp;
        int                         n;
        int                         lo;
        int                         frac;
        int                         i;
        int                         j;
        pct_result_t                res;
        if (stored_count < STORE_DEPTH) begin
            value_store[stored_count] = sample;
            stored_count++;
        end else begin
            store_overflow = 1'b1;
        end
        if (last) begin
            n = stored_count;
            for (i = 0; i < n; i++) sorted_vals[i] = value_store[i];
            for (i = 1; i < n; i++) begin
                key = sorted_vals[i];
                j = i;
                while (j > 0 && sorted_vals[j-1] > key) begin
                    sorted_vals[j] = sorted_vals[j-1];
                    j--;
                end
                sorted_vals[j] = key;
            end
            pct = (pct_setting > PCT_ONE) ? PCT_ONE : pct_setting;
            idx = longint'(pct) * longint'(n - 1);
            lo = int'(idx >>> FRAC_W);
            frac = int'(idx & 64'hFFFF);
            if (lo >= n) lo = n - 1;
            if (frac == 0 || lo + 1 >= n) begin
                interp = longint'(sorted_vals[lo]);
            end else begin
                span = longint'(sorted_vals[lo+1]) - longint'(sorted_vals[lo]);
                interp = longint'(sorted_vals[lo]) + ((span * longint'(frac)) >>> FRAC_W);
            end
            res.value = interp[SAMPLE_W-1:0];
            res.used = n[USED_W-1:0];
            res.dropped = store_overflow;
            expected_results = {expected_results, res};
            if (store_overflow) overflow_sets++;
            sets_closed++;
            stored_count = 0;
            store_overflow = 1'b0;
        end
    endtask

    task automatic check_result(input logic [M_TDATA_W-1:0] word);
        pct_result_t got;
        pct_result_t want;
        got.value = word[31:0];
        got.used = word[40:32];
        got.dropped = word[41];
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected result: value %h used %0d dropped %0b.",
                         got.value, got.used, got.dropped);
        end else begin
            want = expected_results.pop_front();
            if (got.value !== want.value || got.used !== want.used ||
                got.dropped !== want.dropped) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Mismatch on result %0d: expected value %h used %0d dropped %0b,",
                             results_checked, want.value, want.used, want.dropped);
                    $display("    got value %h used %0d dropped %0b.",
                             got.value, got.used, got.dropped);
                end
            end
            results_checked++;
        end
    endtask

    // Every transfer is observed at the edge that completes it.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                pct_setting = cfg_data;
                pct_writes++;
            end
            if (s_tvalid && s_tready) predict_transfer(s_tdata, s_tlast);
            if (m_tvalid && m_tready) check_result(m_tdata);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles--;
        end else if (rx_gap > 0) begin
            m_tready <= 1'b0;
            rx_gap--;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            rx_gap = $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input logic last);
        s_tvalid <= 1'b1;
        s_tdata <= sample;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(input int mode);
        int small_val;
        case (mode)
            1: begin
                small_val = int'($urandom_range(0, 16)) - 8;
                return small_val <<< FRAC_W;
            end
            2: begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h0000_0001;
                    default: return 32'h0000_0000;
                endcase
            end
            3: return $urandom & 32'h8000_03FF;
            4: return $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_set(input int n, input int mode);
        int i;
        for (i = 0; i < n; i++) send_sample(pick_sample(mode), i == n - 1);
    endtask

    task automatic wait_for_results();
        stop_sending();
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_percentile(input logic [PCT_W-1:0] pct);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data <= pct;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_extremes();
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b1);
        send_sample(32'h1234_5678, 1'b1);
        send_sample(32'hFFFD_0000, 1'b0);
        send_sample(32'h0000_0000, 1'b1);
        send_sample(32'h0005_0000, 1'b0);
        send_sample(32'hFFF9_0000, 1'b0);
        send_sample(32'h0000_0001, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h0000_0001, 1'b1);
        write_percentile(PCT_ONE);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b1);
        write_percentile('0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b1);
    endtask

    task automatic test_percentile_settings();
        logic [PCT_W-1:0] settings [8];
        int k;
        settings = '{17'd0, 17'd1, 17'd65535, PCT_ONE, 17'd65537, 17'h1FFFF,
                     PCT_RESET, 17'd21845};
        for (k = 0; k < 8; k++) begin
            write_percentile(settings[k]);
            send_set(2, 2);
            send_set($urandom_range(3, 9), 0);
            send_set($urandom_range(2, 6), 1);
        end
    endtask

    task automatic test_full_store();
        write_percentile(17'd65535);
        send_set(STORE_DEPTH, 0);
    endtask

    task automatic test_over_capacity();
        write_percentile(17'd40000);
        send_set(STORE_DEPTH + 4, 1);
        send_set(3, 0);
    endtask

    task automatic test_output_backpressure();
        int k;
        write_percentile(17'd50000);
        hold_cycles = 600;
        for (k = 0; k < 8; k++) send_set($urandom_range(2, 5), 0);
        wait_for_results();
    endtask

    task automatic test_random_sets();
        int k;
        int n;
        logic [PCT_W-1:0] pct;
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 7))
                0: pct = '0;
                1: pct = PCT_ONE;
                2: pct = PCT_W'($urandom_range(65537, 131071));
                default: pct = PCT_W'($urandom_range(0, 65536));
            endcase
            write_percentile(pct);
            idling_on = (items_sent + 150 < ITEM_TARGET) && ($urandom_range(0, 3) != 0);
            for (k = 0; k < 6; k++) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                send_set(n, $urandom_range(0, 4));
            end
        end
        idling_on = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_extremes();
        test_percentile_settings();
        test_full_store();
        test_over_capacity();
        test_output_backpressure();
        test_random_sets();
        wait_for_results();
        repeat (40) @(posedge aclk);
        $display("Ran %0d values in %0d sets, %0d of them over capacity, under %0d percentile writes.",
                 items_sent, sets_closed, overflow_sets, pct_writes);
        $display("Checked %0d results with %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
